// File: hdl/cdsd_pkg.sv
package cdsd_pkg;

   // stream widths
   localparam int SAMPLE_W  = 16;
   localparam int SERIAL_W  = 24;
   localparam int LFSR_W    = 15;
   localparam int FLAG_W    = 2;

   // flag positions in req_tuser
   localparam int FLAG_DESCRAMBLE = 0;
   localparam int FLAG_MUTE       = 1;

   // sector geometry defaults
   localparam int WORDS_PER_SECTOR_DEF  = 1176;
   localparam int UNSCRAMBLED_WORDS_DEF = 6;

   localparam logic [LFSR_W-1:0] LFSR_SEED = LFSR_W'(1);

   typedef logic [SAMPLE_W-1:0] key_type;
   typedef logic [LFSR_W-1:0]   lfsr_type;

   // eight steps of x^15 + x + 1, shifting right
   function automatic lfsr_type lfsr_step8(input lfsr_type r);
      lfsr_type v;
      v = r;
      for (int n = 0; n < 8; n++) begin
         v = {v[0] ^ v[1], v[LFSR_W-1:1]};
      end
      return v;
   endfunction

   // reverse bit order over the sample width
   function automatic key_type reverse16(input key_type v);
      key_type r;
      for (int n = 0; n < SAMPLE_W; n++) begin
         r[n] = v[SAMPLE_W-1-n];
      end
      return r;
   endfunction

   // serial audio word: reversed sample in the top, low byte copies bit 8; zero when muted
   function automatic logic [SERIAL_W-1:0] format_word(input key_type sample,
                                                      input logic mute);
      key_type rev;
      rev = reverse16(sample);
      if (mute) begin
         return '0;
      end
      return {rev, {8{rev[0]}}};
   endfunction

endpackage

// File: hdl/cd_sector_descramble_i2s_format_core.sv
// CD sector descrambler and serial-audio formatter. Takes one 16-bit sector word
// per transfer and returns one 24-bit serial word per transfer: the word is XORed
// with the ECMA-130 scrambler key on data tracks (sync words get no key), bit
// reversed, shifted left by 8 with the low byte filled from bit 8, or zero when
// muted; rsp_tlast marks the last word of each sector. The keys of a whole sector
// sit in an on-chip key table indexed by the word counter; after reset the table
// is filled once, one entry per cycle, and req_tready stays low until it is full.
// From then on one word is taken every cycle while the output is not stalled; a
// request passes the registered key-table read and then the output register on
// its way to the result.
module cd_sector_descramble_i2s_format_core #(
   parameter int WORDS_PER_SECTOR  = cdsd_pkg::WORDS_PER_SECTOR_DEF,
   parameter int UNSCRAMBLED_WORDS = cdsd_pkg::UNSCRAMBLED_WORDS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [cdsd_pkg::SAMPLE_W-1:0] req_tdata,  // [15:0] sample_word
   input  logic [cdsd_pkg::FLAG_W-1:0]   req_tuser,  // [0] descramble, [1] mute_output
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [cdsd_pkg::SERIAL_W-1:0] rsp_tdata,  // [23:0] serial_word
   output logic                          rsp_tlast   // sector_end
);
   import cdsd_pkg::*;

   localparam int POS_W = $clog2(WORDS_PER_SECTOR);
   localparam logic [POS_W-1:0] LAST_POS  = POS_W'(WORDS_PER_SECTOR - 1);
   localparam logic [POS_W-1:0] SYNC_ENDS = POS_W'(UNSCRAMBLED_WORDS);

   // key table, one entry per word of a sector
   key_type key_mem [WORDS_PER_SECTOR];

   logic             fill_busy_ff, fill_busy_in;
   logic [POS_W-1:0] fill_pos_ff, fill_pos_in;
   lfsr_type         fill_lfsr_ff, fill_lfsr_in;
   lfsr_type         lfsr_mid;
   key_type          fill_key;

   logic [POS_W-1:0] word_pos_ff, word_pos_in;

   logic             s1_valid_ff, s1_valid_in;
   key_type          s1_sample_ff;
   logic             s1_scr_ff, s1_mute_ff, s1_last_ff;
   key_type          key_rd_ff;

   logic             out_valid_ff, out_valid_in;
   logic [SERIAL_W-1:0] out_data_ff;
   logic             out_last_ff;

   logic             req_xfer, out_free, s1_move, pos_last;

   // table fill: walk the sector once, stepping the LFSR 16 times per scrambled word
   always_comb begin
      lfsr_mid     = lfsr_step8(fill_lfsr_ff);
      fill_key     = '0;
      fill_lfsr_in = fill_lfsr_ff;
      if (fill_pos_ff >= SYNC_ENDS) begin
         fill_key     = {lfsr_mid[7:0], fill_lfsr_ff[7:0]};
         fill_lfsr_in = lfsr_step8(lfsr_mid);
      end
      fill_pos_in  = fill_pos_ff + POS_W'(1);
      fill_busy_in = fill_busy_ff && (fill_pos_ff != LAST_POS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_busy_ff <= 1'b1;
         fill_pos_ff  <= '0;
         fill_lfsr_ff <= LFSR_SEED;
      end else if (fill_busy_ff) begin
         fill_busy_ff <= fill_busy_in;
         fill_pos_ff  <= fill_pos_in;
         fill_lfsr_ff <= fill_lfsr_in;
      end
   end

   // handshake and pipeline control
   always_comb begin
      out_free     = !out_valid_ff || rsp_tready;
      s1_move      = s1_valid_ff && out_free;
      req_tready   = !fill_busy_ff && (!s1_valid_ff || out_free);
      req_xfer     = req_tvalid && req_tready;
      pos_last     = word_pos_ff >= LAST_POS;
      word_pos_in  = pos_last ? '0 : word_pos_ff + POS_W'(1);
      s1_valid_in  = req_xfer || (s1_valid_ff && !s1_move);
      out_valid_in = s1_move || (out_valid_ff && !rsp_tready);
   end

   // key table write during fill, registered read on each request transfer
   always_ff @(posedge clock) begin
      if (fill_busy_ff) begin
         key_mem[fill_pos_ff] <= fill_key;
      end
      if (req_xfer) begin
         key_rd_ff <= key_mem[word_pos_ff];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         word_pos_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            word_pos_ff <= word_pos_in;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_sample_ff <= req_tdata;
         s1_scr_ff    <= req_tuser[FLAG_DESCRAMBLE];
         s1_mute_ff   <= req_tuser[FLAG_MUTE];
         s1_last_ff   <= pos_last;
      end
      if (s1_move) begin
         out_data_ff <= format_word(s1_scr_ff ? (s1_sample_ff ^ key_rd_ff) : s1_sample_ff,
                                    s1_mute_ff);
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// File: hdl/cdsd_checker.sv
module cdsd_checker #(
   parameter int WORDS_PER_SECTOR = cdsd_pkg::WORDS_PER_SECTOR_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [cdsd_pkg::SERIAL_W-1:0] rsp_tdata,
   input logic                          rsp_tlast
);
   import cdsd_pkg::*;

   localparam int CNT_W = $clog2(WORDS_PER_SECTOR);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WORDS_PER_SECTOR - 1);

   logic [CNT_W-1:0] rsp_cnt_ff;

   // count result transfers within the current sector
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_cnt_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_cnt_ff <= rsp_tlast ? '0 : rsp_cnt_ff + CNT_W'(1);
      end
   end

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // key table fill keeps input closed and output empty after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("transfer possible straight after reset");

   // low byte always copies bit 8
   a_low_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] == {8{rsp_tdata[8]}}))
      else $error("low byte not filled from bit 8");

   // sector end exactly on every WORDS_PER_SECTOR-th result
   a_sector_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_cnt_ff == LAST_CNT)))
      else $error("sector end out of place");

endmodule

bind cd_sector_descramble_i2s_format_core cdsd_checker #(
   .WORDS_PER_SECTOR(WORDS_PER_SECTOR)
) u_cdsd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
